[design/ffba_pkg.sv]
// ----------------------------------------------------------------------------
// ffba_pkg
// shared types, codes and default sizes of the first-fit block allocator
// ----------------------------------------------------------------------------
package ffba_pkg;

	localparam int unsigned FIELD_W        = 21;
	localparam int unsigned REGION_DEFAULT = 1024 * 1024;
	localparam int unsigned HEADER_DEFAULT = 24;
	localparam int unsigned BLOCKS_DEFAULT = 64;

	typedef enum logic [1:0] {
		OP_ALLOC  = 2'd0,
		OP_FREE   = 2'd1,
		OP_REINIT = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOFIT   = 2'd1,
		ST_NULL    = 2'd2,
		ST_UNKNOWN = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_WALK,
		S_SPLIT2,
		S_FNEXT,
		S_DONE
	} state_t;

endpackage

[design/ffba_ram.sv]
// ----------------------------------------------------------------------------
// ffba_ram
// single write port, single registered read port memory
// ----------------------------------------------------------------------------
module ffba_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[design/first_fit_block_allocator_unit.sv]
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit
// first-fit allocator over an address-ordered chain of headed blocks
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | word
//  in      | input     | in_valid / in_ready  | op, request_bytes, release_offset
//  out     | output    | out_valid / out_ready| payload_offset, status, used_bytes
//
//  an allocate or free walks the chain one block per cycle through the slot
//  table read port; a split adds the S_SPLIT2 write and a matched free whose
//  block has a follower adds the S_FNEXT write
//  null free, reinitialize and unused codes skip the walk
//  after reset the init state writes slot zero before in_ready rises
//  in_ready is high in idle; a finished word waits in the output register
//  while the next item is taken
// ----------------------------------------------------------------------------
module first_fit_block_allocator_unit #(
	parameter int unsigned REGION_BYTES = ffba_pkg::REGION_DEFAULT,
	parameter int unsigned HEADER_BYTES = ffba_pkg::HEADER_DEFAULT,
	parameter int unsigned MAX_BLOCKS   = ffba_pkg::BLOCKS_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   op,
	input  logic [ffba_pkg::FIELD_W-1:0] request_bytes,
	input  logic [ffba_pkg::FIELD_W-1:0] release_offset,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ffba_pkg::FIELD_W-1:0] payload_offset,
	output logic [1:0]                   status,
	output logic [ffba_pkg::FIELD_W-1:0] used_bytes
);

	localparam int unsigned FW     = ffba_pkg::FIELD_W;
	localparam int unsigned IDX_W  = $clog2(MAX_BLOCKS);
	localparam int unsigned SUCC_W = $clog2(MAX_BLOCKS + 1);
	localparam int unsigned WORD_W = 2 * FW + 1 + SUCC_W;
	localparam logic [SUCC_W-1:0] END_MARK   = SUCC_W'(MAX_BLOCKS);
	localparam logic [FW-1:0]     HDR        = FW'(HEADER_BYTES);
	localparam logic [FW-1:0]     FIRST_SIZE = FW'(REGION_BYTES - HEADER_BYTES);

	ffba_pkg::state_t  state_q, state_d;
	logic [1:0]        op_q;
	logic [FW-1:0]     req_q, off_q;
	logic              item_q;
	logic [IDX_W-1:0]  cur_q, spare_q;
	logic [FW-1:0]     cur_start_q, cur_size_q;
	logic              cur_used_q;
	logic [SUCC_W-1:0] cur_succ_q;
	logic [FW-1:0]     res_off_q;
	ffba_pkg::status_t res_status_q;
	logic [FW-1:0]     used_q;
	logic [SUCC_W-1:0] fresh_q, sp_q;
	logic              out_valid_q;
	logic [FW-1:0]     out_off_q, out_used_q;
	logic [1:0]        out_status_q;

	// slot table ports
	logic              tab_we;
	logic [IDX_W-1:0]  tab_waddr, tab_raddr;
	logic [WORD_W-1:0] tab_wdata, tab_rdata;
	// recycled slot stack ports
	logic              stk_we;
	logic [IDX_W-1:0]  stk_top;

	logic [FW-1:0]     rd_start, rd_size;
	logic              rd_used;
	logic [SUCC_W-1:0] rd_succ;
	logic              accept, out_free, fit, split_ok, match, at_end, spare_avail;
	logic [IDX_W-1:0]  spare_idx;
	logic [FW:0]       need, start_hdr;

	assign rd_start = tab_rdata[WORD_W-1 -: FW];
	assign rd_size  = tab_rdata[WORD_W-FW-1 -: FW];
	assign rd_used  = tab_rdata[SUCC_W];
	assign rd_succ  = tab_rdata[SUCC_W-1:0];

	assign accept      = in_valid && in_ready;
	assign out_free    = !out_valid_q || out_ready;
	assign need        = {1'b0, req_q} + {1'b0, HDR} + (FW+1)'(1);
	assign start_hdr   = {1'b0, rd_start} + {1'b0, HDR};
	assign fit         = !rd_used && (rd_size >= req_q);
	assign spare_avail = (sp_q != '0) || (fresh_q < END_MARK);
	assign spare_idx   = (sp_q != '0) ? stk_top : fresh_q[IDX_W-1:0];
	assign split_ok    = ({1'b0, rd_size} >= need) && spare_avail;
	assign match       = start_hdr == {1'b0, off_q};
	assign at_end      = rd_succ == END_MARK;

	ffba_ram #(.WIDTH(WORD_W), .DEPTH(MAX_BLOCKS)) u_table (
		.clk   (clk),
		.we    (tab_we),
		.waddr (tab_waddr),
		.wdata (tab_wdata),
		.raddr (tab_raddr),
		.rdata (tab_rdata)
	);

	ffba_ram #(.WIDTH(IDX_W), .DEPTH(MAX_BLOCKS)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (sp_q[IDX_W-1:0]),
		.wdata (cur_succ_q[IDX_W-1:0]),
		.raddr (IDX_W'(sp_q - SUCC_W'(1))),
		.rdata (stk_top)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffba_pkg::S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		tab_we    = 1'b0;
		tab_waddr = cur_q;
		tab_wdata = {rd_start, rd_size, 1'b0, rd_succ};
		tab_raddr = '0;
		stk_we    = 1'b0;
		in_ready  = 1'b0;
		case (state_q)
			ffba_pkg::S_INIT: begin
				tab_we    = 1'b1;
				tab_waddr = '0;
				tab_wdata = {{FW{1'b0}}, FIRST_SIZE, 1'b0, END_MARK};
				state_d   = item_q ? ffba_pkg::S_DONE : ffba_pkg::S_IDLE;
			end
			ffba_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (accept) begin
					case (op)
						ffba_pkg::OP_ALLOC: state_d = ffba_pkg::S_WALK;
						ffba_pkg::OP_FREE: begin
							state_d = (release_offset == '0) ? ffba_pkg::S_DONE
								: ffba_pkg::S_WALK;
						end
						ffba_pkg::OP_REINIT: state_d = ffba_pkg::S_INIT;
						default: state_d = ffba_pkg::S_DONE;
					endcase
				end
			end
			ffba_pkg::S_WALK: begin
				tab_raddr = rd_succ[IDX_W-1:0];
				if (op_q == ffba_pkg::OP_ALLOC) begin
					if (fit) begin
						tab_we = 1'b1;
						if (split_ok) begin
							// remainder goes to the spare slot, current block next cycle
							tab_waddr = spare_idx;
							tab_wdata = {FW'(start_hdr + {1'b0, req_q}),
								FW'(rd_size - req_q - HDR), 1'b0, rd_succ};
							state_d   = ffba_pkg::S_SPLIT2;
						end else begin
							tab_wdata = {rd_start, rd_size, 1'b1, rd_succ};
							state_d   = ffba_pkg::S_DONE;
						end
					end else if (at_end) begin
						state_d = ffba_pkg::S_DONE;
					end
				end else begin
					if (match) begin
						if (at_end) begin
							tab_we  = 1'b1;
							state_d = ffba_pkg::S_DONE;
						end else begin
							state_d = ffba_pkg::S_FNEXT;
						end
					end else if (at_end) begin
						state_d = ffba_pkg::S_DONE;
					end
				end
			end
			ffba_pkg::S_SPLIT2: begin
				tab_we    = 1'b1;
				tab_wdata = {cur_start_q, req_q, 1'b1, SUCC_W'(spare_q)};
				state_d   = ffba_pkg::S_DONE;
			end
			ffba_pkg::S_FNEXT: begin
				tab_we = 1'b1;
				if (!rd_used) begin
					// merge with the free follower and recycle its slot
					tab_wdata = {cur_start_q, FW'(cur_size_q + HDR + rd_size), 1'b0, rd_succ};
					stk_we    = 1'b1;
				end else begin
					tab_wdata = {cur_start_q, cur_size_q, 1'b0, cur_succ_q};
				end
				state_d = ffba_pkg::S_DONE;
			end
			ffba_pkg::S_DONE: begin
				if (out_free) begin
					state_d = ffba_pkg::S_IDLE;
				end
			end
			default: state_d = ffba_pkg::S_INIT;
		endcase
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_q      <= 1'b0;
			fresh_q     <= SUCC_W'(1);
			sp_q        <= '0;
			used_q      <= HDR;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ffba_pkg::S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ffba_pkg::S_INIT: begin
					item_q  <= 1'b0;
					fresh_q <= SUCC_W'(1);
					sp_q    <= '0;
					used_q  <= HDR;
				end
				ffba_pkg::S_IDLE: begin
					if (accept) begin
						item_q <= 1'b1;
					end
				end
				ffba_pkg::S_WALK: begin
					if (op_q == ffba_pkg::OP_ALLOC) begin
						if (fit) begin
							if (split_ok) begin
								used_q <= used_q + HDR + req_q;
								if (sp_q != '0) begin
									sp_q <= sp_q - SUCC_W'(1);
								end else begin
									fresh_q <= fresh_q + SUCC_W'(1);
								end
							end else begin
								used_q <= used_q + rd_size;
							end
						end
					end else if (match && at_end && rd_used) begin
						used_q <= used_q - rd_size;
					end
				end
				ffba_pkg::S_FNEXT: begin
					if (!rd_used) begin
						used_q <= used_q - (cur_used_q ? cur_size_q : '0) - HDR;
						sp_q   <= sp_q + SUCC_W'(1);
					end else if (cur_used_q) begin
						used_q <= used_q - cur_size_q;
					end
				end
				ffba_pkg::S_DONE: begin
					item_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// item and walk payload
	always_ff @(posedge clk) begin
		case (state_q)
			ffba_pkg::S_IDLE: begin
				if (accept) begin
					op_q      <= op;
					req_q     <= request_bytes;
					off_q     <= release_offset;
					cur_q     <= '0;
					res_off_q <= '0;
					res_status_q <= (op == ffba_pkg::OP_FREE && release_offset == '0)
						? ffba_pkg::ST_NULL : ffba_pkg::ST_OK;
				end
			end
			ffba_pkg::S_WALK: begin
				cur_start_q <= rd_start;
				cur_size_q  <= rd_size;
				cur_used_q  <= rd_used;
				cur_succ_q  <= rd_succ;
				spare_q     <= spare_idx;
				if (op_q == ffba_pkg::OP_ALLOC) begin
					if (fit) begin
						res_off_q <= start_hdr[FW-1:0];
					end else if (at_end) begin
						res_status_q <= ffba_pkg::ST_NOFIT;
					end else begin
						cur_q <= rd_succ[IDX_W-1:0];
					end
				end else if (!match) begin
					if (at_end) begin
						res_status_q <= ffba_pkg::ST_UNKNOWN;
					end else begin
						cur_q <= rd_succ[IDX_W-1:0];
					end
				end
			end
			ffba_pkg::S_DONE: begin
				if (out_free) begin
					out_off_q    <= res_off_q;
					out_status_q <= res_status_q;
					out_used_q   <= used_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign payload_offset = out_off_q;
	assign status         = out_status_q;
	assign used_bytes     = out_used_q;

endmodule
